@@ rtl/stream_find_replace_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Stream find and replace assertion macros
// Immediate-cycle and next-cycle property macros that share one clock and reset.
// ----------------------------------------------------------------------------
`ifndef STREAM_FIND_REPLACE_UNIT_ASSERT_SVH
`define STREAM_FIND_REPLACE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SFR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/sfr_pkg.sv @@
// ----------------------------------------------------------------------------
// Stream find and replace package
// Shared types, register indexes and sizing constants.
// ----------------------------------------------------------------------------
package sfr_pkg;

	localparam int MAX_PATTERN_DEF = 16;
	localparam int WIN_DEPTH       = 16;
	localparam int FILL_W          = 5;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 64;
	localparam int SUB_IDX_W       = 4;

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SUBST_LOW      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SUBST_HIGH     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SUBST_LENGTH   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_EVERY_MATCH    = 3'd6;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} sfr_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_has_byte;
		logic       out_last;
	} sfr_out_t;

	typedef struct packed {
		logic              ins;
		logic              shift;
		logic [FILL_W-1:0] fill;
		logic [7:0]        new_byte;
	} sfr_cell_ctl_t;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_SUBST,
		ST_FLUSH,
		ST_MARK
	} sfr_state_t;

endpackage

@@ rtl/sfr_stream_if.sv @@
// ----------------------------------------------------------------------------
// Stream channel interface
// Valid and ready handshake with a typed payload.
// ----------------------------------------------------------------------------
interface sfr_stream_if #(
	parameter type T = logic [7:0]
) ();
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/sfr_cell.sv @@
// ----------------------------------------------------------------------------
// Window cell
// Holds one window byte, loads from its right neighbor or the incoming byte,
// and reports whether its position agrees with the pattern.
// ----------------------------------------------------------------------------
module sfr_cell #(
	parameter int IDX = 0
) (
	input  logic                  clk,
	input  sfr_pkg::sfr_cell_ctl_t ctl,
	input  logic [7:0]            pat_byte,
	input  logic [7:0]            right_byte,
	output logic [7:0]            byte_q,
	output logic                  match
);
	import sfr_pkg::*;

	localparam logic [FILL_W-1:0] POS      = FILL_W'(IDX);
	localparam logic [FILL_W-1:0] POS_NEXT = FILL_W'(IDX + 1);

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			byte_q <= (ctl.ins && (ctl.fill == POS_NEXT)) ? ctl.new_byte : right_byte;
		end else if (ctl.ins && (ctl.fill == POS)) begin
			byte_q <= ctl.new_byte;
		end
	end

	always_comb begin
		if (POS < ctl.fill) begin
			match = (byte_q == pat_byte);
		end else if (POS == ctl.fill) begin
			match = (ctl.new_byte == pat_byte);
		end else begin
			match = 1'b1;
		end
	end
endmodule

@@ rtl/stream_find_replace_unit.sv @@
// ----------------------------------------------------------------------------
// Stream find and replace unit
// Replaces occurrences of a configured byte pattern in a byte stream.
// ----------------------------------------------------------------------------
// Source bytes enter on the ingress channel, one byte per transfer, with
// in_last on the final byte of a string. Results leave on the egress channel.
// Pattern, replacement and mode are set through the write port; the user
// must do so only while idle, as the block does not enforce it. A result
// appears in the cycle after the transfer that causes it, from the egress
// register. One byte per cycle is taken while no burst is pending and egress
// is not stalled. A match with an n-byte replacement sends its n bytes; the
// end of a string flushes the buffered bytes, then the end marker, or only
// the marker when nothing is buffered. All results pass through the single
// egress register, which takes one result per cycle unless egress is stalled;
// then the result holds and ingress ready stays low. Reset empties the window,
// clears the first-only flag and loads the register reset values.
// ----------------------------------------------------------------------------
module stream_find_replace_unit #(
	parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	sfr_stream_if.sink                       ingress,
	sfr_stream_if.source                     egress,
	input  logic                             cfg_we,
	input  logic [sfr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sfr_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import sfr_pkg::*;

	localparam int NCELL = (MAX_PATTERN < WIN_DEPTH) ? MAX_PATTERN : WIN_DEPTH;

	logic [127:0]          pat_q;
	logic [127:0]          sub_q;
	logic [FILL_W-1:0]     len_q;
	logic [FILL_W-1:0]     slen_q;
	logic                  every_q;
	logic                  rep_q;
	logic                  rep_d;
	logic                  lastp_q;
	logic                  lastp_d;
	logic [FILL_W-1:0]     fill_q;
	logic [FILL_W-1:0]     fill_d;
	logic [SUB_IDX_W-1:0]  sub_idx_q;
	logic [SUB_IDX_W-1:0]  sub_idx_d;
	sfr_state_t            state_q;
	sfr_state_t            state_d;
	logic                  out_valid_q;
	sfr_out_t              out_q;
	sfr_out_t              out_d;
	logic                  emit;
	logic                  load;
	logic                  acc;
	logic                  full;
	logic                  hit;
	logic                  sub_end;
	logic [7:0]            oldest;
	logic [7:0]            sub_byte;
	logic [FILL_W-1:0]     cfg_len;
	logic [FILL_W-1:0]     cfg_slen;
	sfr_in_t               in_item;
	sfr_cell_ctl_t         cell_ctl;
	logic [7:0]            cell_byte [NCELL];
	logic [7:0]            right_w   [NCELL];
	logic [NCELL-1:0]      match_w;

	assign in_item = ingress.payload;
	assign load    = !out_valid_q || egress.ready;
	assign acc     = ingress.valid && ingress.ready;
	assign full    = ((fill_q + FILL_W'(1)) == len_q);
	assign hit     = full && (&match_w) && (every_q || !rep_q);
	assign sub_end = ((FILL_W'(sub_idx_q) + FILL_W'(1)) == slen_q);
	assign oldest  = (fill_q == '0) ? in_item.in_byte : cell_byte[0];
	assign sub_byte = sub_q[{sub_idx_q, 3'b000} +: 8];

	assign egress.valid   = out_valid_q;
	assign egress.payload = out_q;

	always_comb begin
		cfg_len = cfg_data[FILL_W-1:0];
		if (cfg_len == '0) begin
			cfg_len = FILL_W'(1);
		end else if (cfg_len > FILL_W'(NCELL)) begin
			cfg_len = FILL_W'(NCELL);
		end
		cfg_slen = cfg_data[FILL_W-1:0];
		if (cfg_slen > FILL_W'(16)) begin
			cfg_slen = FILL_W'(16);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q   <= '0;
			sub_q   <= '0;
			len_q   <= FILL_W'(1);
			slen_q  <= '0;
			every_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PATTERN_LOW:    pat_q[63:0]   <= cfg_data;
				REG_PATTERN_HIGH:   pat_q[127:64] <= cfg_data;
				REG_PATTERN_LENGTH: len_q         <= cfg_len;
				REG_SUBST_LOW:      sub_q[63:0]   <= cfg_data;
				REG_SUBST_HIGH:     sub_q[127:64] <= cfg_data;
				REG_SUBST_LENGTH:   slen_q        <= cfg_slen;
				REG_EVERY_MATCH:    every_q       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	for (genvar g = 0; g < NCELL; g++) begin : g_cell
		if (g < NCELL - 1) begin : g_mid
			assign right_w[g] = cell_byte[g + 1];
		end else begin : g_end
			assign right_w[g] = in_item.in_byte;
		end

		sfr_cell #(
			.IDX(g)
		) u_cell (
			.clk        (clk),
			.ctl        (cell_ctl),
			.pat_byte   (pat_q[8*g +: 8]),
			.right_byte (right_w[g]),
			.byte_q     (cell_byte[g]),
			.match      (match_w[g])
		);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_RUN: begin
				if (acc) begin
					if (hit && (slen_q > FILL_W'(1))) begin
						state_d = ST_SUBST;
					end else if (in_item.in_last) begin
						if (!hit && (!full || (fill_q != '0))) begin
							state_d = ST_FLUSH;
						end else begin
							state_d = ST_MARK;
						end
					end
				end
			end
			ST_SUBST: begin
				if (load && sub_end) begin
					state_d = lastp_q ? ST_MARK : ST_RUN;
				end
			end
			ST_FLUSH: begin
				if (load && (fill_q == FILL_W'(1))) begin
					state_d = ST_MARK;
				end
			end
			ST_MARK: begin
				if (load) begin
					state_d = ST_RUN;
				end
			end
			default: state_d = ST_RUN;
		endcase
	end

	always_comb begin
		ingress.ready     = 1'b0;
		emit              = 1'b0;
		out_d             = '0;
		cell_ctl.ins      = 1'b0;
		cell_ctl.shift    = 1'b0;
		cell_ctl.fill     = fill_q;
		cell_ctl.new_byte = in_item.in_byte;
		fill_d            = fill_q;
		rep_d             = rep_q;
		sub_idx_d         = sub_idx_q;
		lastp_d           = lastp_q;
		case (state_q)
			ST_RUN: begin
				ingress.ready = load;
				if (acc) begin
					lastp_d      = in_item.in_last;
					cell_ctl.ins = 1'b1;
					if (hit) begin
						fill_d = '0;
						rep_d  = 1'b1;
						if (slen_q != '0) begin
							emit               = 1'b1;
							out_d.out_byte     = sub_q[7:0];
							out_d.out_has_byte = 1'b1;
							sub_idx_d          = SUB_IDX_W'(1);
						end
					end else if (full) begin
						cell_ctl.shift     = 1'b1;
						emit               = 1'b1;
						out_d.out_byte     = oldest;
						out_d.out_has_byte = 1'b1;
					end else begin
						fill_d = fill_q + FILL_W'(1);
					end
					if (in_item.in_last) begin
						rep_d = 1'b0;
					end
				end
			end
			ST_SUBST: begin
				if (load) begin
					emit               = 1'b1;
					out_d.out_byte     = sub_byte;
					out_d.out_has_byte = 1'b1;
					sub_idx_d          = sub_idx_q + SUB_IDX_W'(1);
				end
			end
			ST_FLUSH: begin
				if (load) begin
					emit               = 1'b1;
					out_d.out_byte     = cell_byte[0];
					out_d.out_has_byte = 1'b1;
					cell_ctl.shift     = 1'b1;
					fill_d             = fill_q - FILL_W'(1);
				end
			end
			ST_MARK: begin
				if (load) begin
					emit           = 1'b1;
					out_d.out_last = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			fill_q      <= '0;
			rep_q       <= 1'b0;
			lastp_q     <= 1'b0;
			sub_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rep_q     <= rep_d;
			lastp_q   <= lastp_d;
			sub_idx_q <= sub_idx_d;
			if (cfg_we && (cfg_index == REG_PATTERN_LENGTH)) begin
				fill_q <= '0;
			end else begin
				fill_q <= fill_d;
			end
			if (load) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && emit) begin
			out_q <= out_d;
		end
	end
endmodule

@@ rtl/sfr_checker.sv @@
// ----------------------------------------------------------------------------
// Stream find and replace port checker
// Watches the channels of the top level for handshake and framing slips.
// ----------------------------------------------------------------------------
`include "stream_find_replace_unit_assert.svh"

module sfr_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              in_last,
	input logic              out_valid,
	input logic              out_ready,
	input sfr_pkg::sfr_out_t out_item
);
	import sfr_pkg::*;

	`SFR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item), "egress result changed while stalled")
	`SFR_ASSERT_NOW(a_backpressure, out_valid && !out_ready, !in_ready, "ingress ready while egress is stalled")
	`SFR_ASSERT_NOW(a_marker_form, out_valid, (out_item.out_last == !out_item.out_has_byte) && (out_item.out_has_byte || (out_item.out_byte == 8'd0)), "malformed end marker")
	`SFR_ASSERT_NEXT(a_last_drains, in_valid && in_ready && in_last, !in_ready, "transfer accepted before end of string drained")
endmodule

bind stream_find_replace_unit sfr_checker u_sfr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (ingress.valid),
	.in_ready  (ingress.ready),
	.in_last   (ingress.payload.in_last),
	.out_valid (egress.valid),
	.out_ready (egress.ready),
	.out_item  (egress.payload)
);
